### hw/rtl/mpg_pkg.sv
// Package for the multichannel PWM generator: field widths, reset defaults,
// command codes, controller states and the control/status structs.
// No dependencies.
package mpg_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int MAX_CHANNELS = 16;

    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 4;
    localparam int FREQ_W  = 32;
    localparam int DUTY_W  = 17;
    localparam int TICK_W  = 25;
    localparam int PULSE_W = 32;
    localparam int PINS_W  = 8;

    // Divider: quotient bits, dividend width and step counter width.
    localparam int QUOT_W = 25;
    localparam int DIVD_W = 33;
    localparam int CNT_W  = 5;

    localparam int PROD_W = TICK_W + DUTY_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 144;

    localparam logic [DIVD_W-1:0] BASE_Q   = 33'd25600000;
    localparam logic [DIVD_W-1:0] BASE_Q2  = 33'd51200000;
    localparam logic [TICK_W-1:0] DEF_PERIOD = 25'd1000;
    localparam logic [TICK_W-1:0] DEF_WINDOW = 25'd500;
    localparam logic [DUTY_W-1:0] DEF_DUTY   = 17'd32768;
    localparam logic [DUTY_W-1:0] DUTY_ONE   = 17'd65536;
    localparam logic [PROD_W-1:0] ROUND_HALF = 42'd32768;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_GET  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic need_mul;
        logic out_free;
    } ctrl_status_t;

endpackage

### hw/rtl/mpg_ctrl.sv
// Controller of the PWM generator: sequences decode, division, multiply
// and commit for one item at a time.
// Depends on mpg_pkg.
module mpg_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output mpg_pkg::ctrl_cmd_t    cmd,
    input  mpg_pkg::ctrl_status_t status
);

    mpg_pkg::ctrl_state_t state_reg;
    mpg_pkg::ctrl_state_t state_next;
    logic [mpg_pkg::CNT_W-1:0] step_cnt_reg;
    logic [mpg_pkg::CNT_W-1:0] step_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mpg_pkg::ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            mpg_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = mpg_pkg::ST_DECIDE;
            end
            mpg_pkg::ST_DECIDE:
            begin
                if (status.need_div)
                begin
                    state_next    = mpg_pkg::ST_DIV;
                    step_cnt_next = mpg_pkg::CNT_W'(mpg_pkg::QUOT_W - 1);
                end
                else
                    state_next = mpg_pkg::ST_DONE;
            end
            mpg_pkg::ST_DIV:
            begin
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0)
                    state_next = status.need_mul ? mpg_pkg::ST_MUL : mpg_pkg::ST_DONE;
            end
            mpg_pkg::ST_MUL:
                state_next = mpg_pkg::ST_DONE;
            mpg_pkg::ST_DONE:
            begin
                if (status.out_free)
                    state_next = mpg_pkg::ST_IDLE;
            end
            default:
                state_next = mpg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            mpg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            mpg_pkg::ST_DECIDE:
                cmd.div_start = status.need_div;
            mpg_pkg::ST_DIV:
                cmd.div_step = 1'b1;
            mpg_pkg::ST_MUL:
                cmd.mul_load = 1'b1;
            mpg_pkg::ST_DONE:
                cmd.commit = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

### hw/rtl/mpg_datapath.sv
// Datapath of the PWM generator: per-channel state, item registers, the
// shared restoring divider, the duty multiplier and the output register.
// Depends on mpg_pkg.
module mpg_datapath #(
    parameter int CHANNELS = mpg_pkg::CHANNELS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [mpg_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [mpg_pkg::CMD_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mpg_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  mpg_pkg::ctrl_cmd_t                 cmd,
    output mpg_pkg::ctrl_status_t              status
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW = mpg_pkg::TICK_W;

    // Per-channel state.
    logic [TW-1:0]                   period_reg   [CHANNELS];
    logic [TW-1:0]                   period_next  [CHANNELS];
    logic [TW-1:0]                   window_reg   [CHANNELS];
    logic [TW-1:0]                   window_next  [CHANNELS];
    logic [TW-1:0]                   pos_reg      [CHANNELS];
    logic [TW-1:0]                   pos_next     [CHANNELS];
    logic [mpg_pkg::PULSE_W-1:0]     pulse_reg    [CHANNELS];
    logic [mpg_pkg::PULSE_W-1:0]     pulse_next   [CHANNELS];
    logic [mpg_pkg::DUTY_W-1:0]      dset_reg     [CHANNELS];
    logic [mpg_pkg::DUTY_W-1:0]      dset_next    [CHANNELS];
    logic [CHANNELS-1:0]             running_reg;
    logic [CHANNELS-1:0]             running_next;
    logic [CHANNELS-1:0]             pin_reg;
    logic [CHANNELS-1:0]             pin_next;
    logic [CHANNELS-1:0]             done_vec;

    // Item registers.
    mpg_pkg::cmd_t                   cmd_reg;
    logic [mpg_pkg::CHAN_W-1:0]      chan_reg;
    logic [mpg_pkg::FREQ_W-1:0]      freq_reg;
    logic [mpg_pkg::DUTY_W-1:0]      duty_reg;
    logic [mpg_pkg::DUTY_W-1:0]      duty_in;
    logic                            chan_ok;
    logic [IDX_W-1:0]                idx;

    // Divider.
    logic [mpg_pkg::DIVD_W-1:0]      rem_reg;
    logic [mpg_pkg::QUOT_W-1:0]      dvd_reg;
    logic [mpg_pkg::DIVD_W-1:0]      divisor_reg;
    logic [mpg_pkg::QUOT_W-1:0]      quot_reg;
    logic [mpg_pkg::DIVD_W-1:0]      dvd_init;
    logic [mpg_pkg::DIVD_W-1:0]      divisor_init;
    logic [mpg_pkg::DIVD_W:0]        trial;
    logic                            trial_ge;

    // Multiplier and window.
    logic [mpg_pkg::PROD_W-1:0]      prod_reg;
    logic [TW-1:0]                   per_reg;
    logic [TW-1:0]                   per_clamped;
    logic [mpg_pkg::PROD_W-1:0]      prod_round;
    logic [mpg_pkg::PROD_W-17:0]     window_raw;
    logic [TW-1:0]                   window_new;

    // Output.
    logic                            out_valid_reg;
    logic [mpg_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [mpg_pkg::PINS_W-1:0]      pins_vec;
    logic [mpg_pkg::PINS_W-1:0]      done_bits;
    logic                            accepted;
    logic                            is_get;

    assign duty_in = s_tdata[52:36];
    assign chan_ok = {1'b0, chan_reg} < (mpg_pkg::CHAN_W + 1)'(CHANNELS);
    assign idx     = chan_ok ? chan_reg[IDX_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= mpg_pkg::cmd_t'(s_tuser);
            chan_reg <= s_tdata[3:0];
            freq_reg <= s_tdata[35:4];
            duty_reg <= (duty_in > mpg_pkg::DUTY_ONE) ? mpg_pkg::DUTY_ONE : duty_in;
        end
    end

    always_comb
    begin
        status.need_mul = (cmd_reg == mpg_pkg::CMD_SET);
        status.need_div = chan_ok &&
            (((cmd_reg == mpg_pkg::CMD_SET) && (freq_reg != '0)) ||
             ((cmd_reg == mpg_pkg::CMD_GET) && running_reg[idx]));
        status.out_free = !out_valid_reg || m_tready;
    end

    // A set divides (2*BASE + f) by 2f for a rounded period; a get divides
    // BASE by the stored period for the realized frequency.
    always_comb
    begin
        if (cmd_reg == mpg_pkg::CMD_SET)
        begin
            dvd_init     = mpg_pkg::BASE_Q2 + {1'b0, freq_reg};
            divisor_init = {freq_reg, 1'b0};
        end
        else
        begin
            dvd_init     = mpg_pkg::BASE_Q;
            divisor_init = {{(mpg_pkg::DIVD_W - TW){1'b0}}, period_reg[idx]};
        end
    end

    assign trial    = {rem_reg, dvd_reg[mpg_pkg::QUOT_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            // The quotient fits in QUOT_W bits, so the top dividend bits are
            // already below the divisor.
            rem_reg     <= {{mpg_pkg::QUOT_W{1'b0}},
                            dvd_init[mpg_pkg::DIVD_W-1:mpg_pkg::QUOT_W]};
            dvd_reg     <= dvd_init[mpg_pkg::QUOT_W-1:0];
            divisor_reg <= divisor_init;
            quot_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? mpg_pkg::DIVD_W'(trial - {1'b0, divisor_reg})
                                 : trial[mpg_pkg::DIVD_W-1:0];
            dvd_reg  <= {dvd_reg[mpg_pkg::QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[mpg_pkg::QUOT_W-2:0], trial_ge};
        end
    end

    assign per_clamped = (quot_reg == '0) ? TW'(1) : quot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            per_reg  <= per_clamped;
            prod_reg <= mpg_pkg::PROD_W'(per_clamped) * mpg_pkg::PROD_W'(duty_reg);
        end
    end

    assign prod_round = prod_reg + mpg_pkg::ROUND_HALF;
    assign window_raw = prod_round[mpg_pkg::PROD_W-1:16];
    assign window_new = (window_raw > {1'b0, per_reg}) ? per_reg : window_raw[TW-1:0];

    always_comb
    begin
        logic [TW-1:0] pos_inc;
        pos_inc = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            period_next[i] = period_reg[i];
            window_next[i] = window_reg[i];
            pos_next[i]    = pos_reg[i];
            pulse_next[i]  = pulse_reg[i];
            dset_next[i]   = dset_reg[i];
        end
        running_next = running_reg;
        pin_next     = pin_reg;
        done_vec     = '0;
        if (cmd.commit)
        begin
            case (cmd_reg)
                mpg_pkg::CMD_TICK:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (running_reg[i])
                        begin
                            pos_inc = pos_reg[i] + 1'b1;
                            if (pos_inc >= period_reg[i])
                            begin
                                pos_next[i]   = '0;
                                pulse_next[i] = pulse_reg[i] + 1'b1;
                                done_vec[i]   = 1'b1;
                            end
                            else
                                pos_next[i] = pos_inc;
                            pin_next[i] = pos_next[i] < window_reg[i];
                        end
                    end
                end
                mpg_pkg::CMD_SET:
                begin
                    if (chan_ok)
                    begin
                        dset_next[idx] = duty_reg;
                        pos_next[idx]  = '0;
                        if (freq_reg == '0)
                        begin
                            running_next[idx] = 1'b0;
                            period_next[idx]  = mpg_pkg::DEF_PERIOD;
                            window_next[idx]  = mpg_pkg::DEF_WINDOW;
                            pin_next[idx]     = 1'b0;
                        end
                        else
                        begin
                            running_next[idx] = 1'b1;
                            period_next[idx]  = per_reg;
                            window_next[idx]  = window_new;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                period_reg[i] <= mpg_pkg::DEF_PERIOD;
                window_reg[i] <= mpg_pkg::DEF_WINDOW;
                pos_reg[i]    <= '0;
                pulse_reg[i]  <= '0;
                dset_reg[i]   <= mpg_pkg::DEF_DUTY;
            end
            running_reg <= '0;
            pin_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                period_reg[i] <= period_next[i];
                window_reg[i] <= window_next[i];
                pos_reg[i]    <= pos_next[i];
                pulse_reg[i]  <= pulse_next[i];
                dset_reg[i]   <= dset_next[i];
            end
            running_reg <= running_next;
            pin_reg     <= pin_next;
        end
    end

    // Only the first eight channels have a bit in the result.
    for (genvar g = 0; g < mpg_pkg::PINS_W; g++)
    begin : g_bits
        if (g < CHANNELS)
        begin : g_live
            assign pins_vec[g]  = pin_next[g];
            assign done_bits[g] = done_vec[g];
        end
        else
        begin : g_none
            assign pins_vec[g]  = 1'b0;
            assign done_bits[g] = 1'b0;
        end
    end

    assign is_get   = (cmd_reg == mpg_pkg::CMD_GET) && chan_ok;
    assign accepted = (cmd_reg == mpg_pkg::CMD_TICK) ||
                      (((cmd_reg == mpg_pkg::CMD_SET) || (cmd_reg == mpg_pkg::CMD_GET))
                       && chan_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg[7:0]   <= pins_vec;
            out_data_reg[15:8]  <= done_bits;
            out_data_reg[16]    <= accepted;
            out_data_reg[17]    <= is_get && running_reg[idx];
            out_data_reg[42:18] <= is_get ? period_reg[idx] : '0;
            out_data_reg[67:43] <= is_get ? window_reg[idx] : '0;
            out_data_reg[84:68] <= is_get ? dset_reg[idx] : '0;
            out_data_reg[109:85] <= (is_get && running_reg[idx]) ? quot_reg : '0;
            out_data_reg[141:110] <= is_get ? pulse_reg[idx] : '0;
            out_data_reg[143:142] <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/multichannel_pwm_generator_unit.sv
// Top level of the multichannel PWM generator: controller plus datapath.
// Depends on mpg_pkg, mpg_ctrl and mpg_datapath.
//
// Usage:
// Items enter on the s_* channel: s_tuser carries the command (tick, set,
// get), s_tdata the channel, the Q24.8 frequency and the Q1.16 duty. Each
// item yields exactly one result item on the m_* channel with the pin
// levels, the period-done bits and, for a get, the channel's settings.
// A tick, a refused item, a set with zero frequency and a get on a stopped
// channel skip the divider; any other set or get goes through the shared
// restoring divider, one quotient bit per cycle, and a set then goes on
// through the duty multiplier. The next item is taken only once the result
// of the last one is registered.
// The result sits in an output register: s_tready returns while it waits,
// and a stalled receiver only holds the block once a second result is ready.
// Reset puts every channel at period 1000, window 500, duty 32768, stopped
// with its pin low, and clears the pulse counts.
module multichannel_pwm_generator_unit #(
    parameter int CHANNELS = mpg_pkg::CHANNELS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: channel[3:0], freq_q[35:4], duty_q[52:36], zero padding
    input  logic [mpg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [mpg_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: pin_levels[7:0], period_done[15:8], accepted[16],
    // chan_active[17], period_out[42:18], duty_ticks_out[67:43],
    // duty_setting_out[84:68], actual_freq[109:85], pulse_count_out[141:110],
    // zero padding
    output logic [mpg_pkg::OUT_TDATA_W-1:0] m_tdata
);

    mpg_pkg::ctrl_cmd_t    ctrl_cmd;
    mpg_pkg::ctrl_status_t ctrl_status;

    mpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (ctrl_cmd),
        .status   (ctrl_status)
    );

    mpg_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (ctrl_cmd),
        .status   (ctrl_status)
    );

endmodule

### hw/rtl/mpg_checker.sv
// Port-level checks for the PWM generator top level, with its bind.
// Depends on mpg_pkg and multichannel_pwm_generator_unit.
module mpg_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mpg_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic [mpg_pkg::CMD_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mpg_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // Only one item is in work at a time.
    a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // A refused item reports no get fields and no wrapped periods.
    a_refused_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[16] |-> (m_tdata[141:8] == '0))
        else $error("refused item carries data");

    // A running channel always has a nonzero period and realized frequency.
    a_active_freq : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> (m_tdata[109:85] != '0) && (m_tdata[42:18] != '0))
        else $error("active channel reports zero period or frequency");

endmodule

bind multichannel_pwm_generator_unit mpg_checker u_mpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
